/* hw/rtl/bcag_pkg.sv */
package bcag_pkg;

  // Storage sizing.
  localparam int MAX_DIMS  = 8;
  localparam int SIDE_BITS = 16;
  localparam int DIM_IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  // Shared divider: 33-bit dividend, 16-bit divisor, one quotient bit a cycle.
  localparam int DVD_W     = 33;
  localparam int DIV_STEPS = DVD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Configuration register indexes.
  localparam int REG_NUM_DIMS = 0;

  // Microcode program counter.
  localparam int PC_W = 4;

  typedef enum logic [3:0] {
    OP_WAIT,      // take one input transaction
    OP_NOP,
    OP_DIV_REM,   // rem <= rem / p
    OP_INC_K,     // next dimension
    OP_RESTART,   // rem <= block number, k <= 0
    OP_DIV_T,     // rem <= rem / p, t <= rem % p
    OP_MUL,       // x <= t * n
    OP_DIV_LO,    // lower <= (x + p - 1) / p
    OP_DIV_HI,    // upper <= (x + n + p - 1) / p
    OP_EMIT,      // corner pair to the output register
    OP_EMIT_OOR   // flagged out-of-range result
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER,   // fall through to the next step
    COND_ALWAYS,
    COND_SET,     // the accepted transaction was a set action
    COND_PZERO,   // block count of the current dimension is zero
    COND_MORE,    // another dimension follows the current one
    COND_REMNZ    // quotient left over after all dimensions
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [PC_W-1:0]  target;
  } uword_t;

  // Step addresses.
  localparam logic [PC_W-1:0] STEP_WAIT    = 4'd0;
  localparam logic [PC_W-1:0] STEP_CHK     = 4'd1;
  localparam logic [PC_W-1:0] STEP_DIV_REM = 4'd2;
  localparam logic [PC_W-1:0] STEP_INC_K   = 4'd3;
  localparam logic [PC_W-1:0] STEP_RESTART = 4'd4;
  localparam logic [PC_W-1:0] STEP_DIV_T   = 4'd5;
  localparam logic [PC_W-1:0] STEP_MUL     = 4'd6;
  localparam logic [PC_W-1:0] STEP_DIV_LO  = 4'd7;
  localparam logic [PC_W-1:0] STEP_DIV_HI  = 4'd8;
  localparam logic [PC_W-1:0] STEP_EMIT    = 4'd9;
  localparam logic [PC_W-1:0] STEP_DONE    = 4'd10;
  localparam logic [PC_W-1:0] STEP_OOR     = 4'd11;

  // Control store. The first pass divides through every dimension to check
  // the range; the second pass repeats the split and emits the corners.
  function automatic uword_t ucode_rom(logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_WAIT};
    case (pc)
      STEP_WAIT:    w = '{op: OP_WAIT,     cond: COND_SET,    target: STEP_WAIT};
      STEP_CHK:     w = '{op: OP_NOP,      cond: COND_PZERO,  target: STEP_OOR};
      STEP_DIV_REM: w = '{op: OP_DIV_REM,  cond: COND_NEVER,  target: STEP_WAIT};
      STEP_INC_K:   w = '{op: OP_INC_K,    cond: COND_MORE,   target: STEP_CHK};
      STEP_RESTART: w = '{op: OP_RESTART,  cond: COND_REMNZ,  target: STEP_OOR};
      STEP_DIV_T:   w = '{op: OP_DIV_T,    cond: COND_NEVER,  target: STEP_WAIT};
      STEP_MUL:     w = '{op: OP_MUL,      cond: COND_NEVER,  target: STEP_WAIT};
      STEP_DIV_LO:  w = '{op: OP_DIV_LO,   cond: COND_NEVER,  target: STEP_WAIT};
      STEP_DIV_HI:  w = '{op: OP_DIV_HI,   cond: COND_NEVER,  target: STEP_WAIT};
      STEP_EMIT:    w = '{op: OP_EMIT,     cond: COND_MORE,   target: STEP_DIV_T};
      STEP_DONE:    w = '{op: OP_NOP,      cond: COND_ALWAYS, target: STEP_WAIT};
      STEP_OOR:     w = '{op: OP_EMIT_OOR, cond: COND_ALWAYS, target: STEP_WAIT};
      default:      w = '{op: OP_NOP,      cond: COND_ALWAYS, target: STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

/* hw/rtl/block_corner_address_generator_core.sv */
// Set transaction: handled in the wait step, no result.
// Query over d dimensions: each 33-bit division runs on the shared
// one-bit-a-cycle divider, four divisions per dimension.
// One query is worked on at a time; the next transaction is taken while the
// last result still waits in the output register.
// Synchronous active-high reset: tables hold ones, num_dims is one, no output.
module block_corner_address_generator_core (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  // dim_select[2:0], side_length[18:3], block_count[34:19],
  // block_number[65:35], zero fill to 72 bits
  input  logic [71:0] s_tdata,
  // action[0]
  input  logic        s_tuser,
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  // dim_out[2:0], lower_corner[18:3], upper_corner[34:19], zero fill to 40 bits
  output logic [39:0] m_tdata,
  output logic        m_tlast,
  // out_of_range[0]
  output logic        m_tuser,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bcag_pkg::*;

  // Input field unpacking.
  logic        action;
  logic [2:0]  dim_select;
  logic [15:0] side_length;
  logic [15:0] block_count;
  logic [30:0] block_number;

  assign action       = s_tuser;
  assign dim_select   = s_tdata[2:0];
  assign side_length  = s_tdata[18:3];
  assign block_count  = s_tdata[34:19];
  assign block_number = s_tdata[65:35];

  // State.
  logic [SIDE_BITS-1:0] side_lengths [MAX_DIMS];
  logic [15:0]          block_counts [MAX_DIMS];
  logic [3:0]           num_dims;

  // Sequencer and datapath registers.
  logic [PC_W-1:0]      pc;
  logic [3:0]           k;
  logic [30:0]          rem;
  logic [30:0]          query_num;
  logic [15:0]          t;
  logic [31:0]          x;
  logic [15:0]          lower;
  logic [15:0]          upper;

  // Divider registers.
  logic                 div_busy;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [DVD_W-1:0]     dvd;
  logic [15:0]          rmd;

  // Output register.
  logic                 out_valid;
  logic [2:0]           out_dim;
  logic [15:0]          out_lower;
  logic [15:0]          out_upper;
  logic                 out_last;
  logic                 out_oor;

  // Combinational signals.
  uword_t               uw;
  logic [3:0]           dims;
  logic [DIM_IDX_W-1:0] kidx;
  logic [15:0]          cur_p;
  logic [15:0]          cur_n;
  logic                 more;
  logic                 cond_true;
  logic                 stall;
  logic                 div_op;
  logic                 div_last;
  logic [DVD_W-1:0]     div_src;
  logic [16:0]          trial;
  logic                 trial_ge;
  logic [15:0]          rmd_next;
  logic [DVD_W-1:0]     dvd_next;
  logic                 in_accept;
  logic                 out_free;
  logic                 cfg_write;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == 1'(REG_NUM_DIMS));
  assign prdata    = (paddr[2] == 1'(REG_NUM_DIMS)) ? {28'd0, num_dims} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_dims <= 4'd1;
    end else if (cfg_write) begin
      num_dims <= pwdata[3:0];
    end
  end

  // Dimensions in use, with zero taken as one and large values saturated.
  always_comb begin
    if (num_dims == 4'd0) begin
      dims = 4'd1;
    end else if (32'(num_dims) > MAX_DIMS) begin
      dims = 4'(MAX_DIMS);
    end else begin
      dims = num_dims;
    end
  end

  // Current table entries.
  assign kidx  = k[DIM_IDX_W-1:0];
  assign cur_p = block_counts[kidx];
  assign cur_n = 16'(side_lengths[kidx]);
  assign more  = (5'(k) + 5'd1) < 5'(dims);

  // Control word and stall decode.
  assign uw        = ucode_rom(pc);
  assign div_op    = (uw.op == OP_DIV_REM) || (uw.op == OP_DIV_T) ||
                     (uw.op == OP_DIV_LO) || (uw.op == OP_DIV_HI);
  assign div_last  = div_busy && (32'(div_cnt) == DIV_STEPS - 1);
  assign out_free  = !out_valid || m_tready;
  assign s_tready  = (uw.op == OP_WAIT);
  assign in_accept = s_tvalid && s_tready;

  always_comb begin
    case (uw.op)
      OP_WAIT:                stall = !s_tvalid;
      OP_DIV_REM, OP_DIV_T,
      OP_DIV_LO, OP_DIV_HI:   stall = !div_last;
      OP_EMIT, OP_EMIT_OOR:   stall = !out_free;
      default:                stall = 1'b0;
    endcase
  end

  always_comb begin
    case (uw.cond)
      COND_NEVER:  cond_true = 1'b0;
      COND_ALWAYS: cond_true = 1'b1;
      COND_SET:    cond_true = !action;
      COND_PZERO:  cond_true = (cur_p == 16'd0);
      COND_MORE:   cond_true = more;
      COND_REMNZ:  cond_true = (rem != 31'd0);
      default:     cond_true = 1'b0;
    endcase
  end

  // Dividend selection for the shared divider.
  always_comb begin
    case (uw.op)
      OP_DIV_LO: div_src = {1'b0, x} + DVD_W'(cur_p) - DVD_W'(1);
      OP_DIV_HI: div_src = {1'b0, x} + DVD_W'(cur_n) + DVD_W'(cur_p) - DVD_W'(1);
      default:   div_src = DVD_W'(rem);
    endcase
  end

  // One restoring step of the divider.
  assign trial    = {rmd, dvd[DVD_W-1]};
  assign trial_ge = trial >= {1'b0, cur_p};
  assign rmd_next = trial_ge ? 16'(trial - {1'b0, cur_p}) : trial[15:0];
  assign dvd_next = {dvd[DVD_W-2:0], trial_ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (div_op) begin
      if (!div_busy) begin
        div_busy <= 1'b1;
      end else if (div_last) begin
        div_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_op) begin
      if (!div_busy) begin
        dvd     <= div_src;
        rmd     <= 16'd0;
        div_cnt <= '0;
      end else begin
        dvd     <= dvd_next;
        rmd     <= rmd_next;
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end
    end
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_WAIT;
    end else if (!stall) begin
      pc <= cond_true ? uw.target : pc + PC_W'(1);
    end
  end

  // Tables: written by a set transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_DIMS; i++) begin
        side_lengths[i] <= SIDE_BITS'(1);
        block_counts[i] <= 16'd1;
      end
    end else if (in_accept && !action && (32'(dim_select) < MAX_DIMS)) begin
      side_lengths[DIM_IDX_W'(dim_select)] <= side_length[SIDE_BITS-1:0];
      block_counts[DIM_IDX_W'(dim_select)] <= block_count;
    end
  end

  // Datapath registers driven by the control word.
  always_ff @(posedge clk) begin
    if (rst) begin
      k <= 4'd0;
    end else if (!stall) begin
      case (uw.op)
        OP_WAIT:    if (action) k <= 4'd0;
        OP_INC_K:   k <= k + 4'd1;
        OP_RESTART: k <= 4'd0;
        OP_EMIT:    if (more) k <= k + 4'd1;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      case (uw.op)
        OP_WAIT: begin
          rem       <= block_number;
          query_num <= block_number;
        end
        OP_DIV_REM: rem <= dvd_next[30:0];
        OP_RESTART: rem <= query_num;
        OP_DIV_T: begin
          rem <= dvd_next[30:0];
          t   <= rmd_next;
        end
        OP_MUL:    x     <= 32'(t) * 32'(cur_n);
        OP_DIV_LO: lower <= dvd_next[15:0];
        OP_DIV_HI: upper <= dvd_next[15:0];
        default:   ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((uw.op == OP_EMIT || uw.op == OP_EMIT_OOR) && out_free) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (uw.op == OP_EMIT) begin
        out_dim   <= k[2:0];
        out_lower <= lower;
        out_upper <= upper;
        out_last  <= !more;
        out_oor   <= 1'b0;
      end else if (uw.op == OP_EMIT_OOR) begin
        out_dim   <= 3'd0;
        out_lower <= 16'd0;
        out_upper <= 16'd0;
        out_last  <= 1'b1;
        out_oor   <= 1'b1;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_upper, out_lower, out_dim};
  assign m_tlast  = out_last;
  assign m_tuser  = out_oor;

endmodule

/* dv/block_corner_address_generator_core_test.sv */
module block_corner_address_generator_core_test;
  import bcag_pkg::*;

  // Action codes carried in s_tuser.
  localparam logic ACT_SET   = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Kinds of block number drawn for a query.
  localparam int NUM_IN  = 0;
  localparam int NUM_OUT = 1;

  localparam logic [2:0]  NUM_DIMS_ADDR = 3'(REG_NUM_DIMS * 4);
  localparam logic [15:0] SIDE_MASK     = 16'((64'd1 << SIDE_BITS) - 1);
  localparam longint unsigned TOTAL_CAP = 64'd1 << 32;

  // Worst query, counted per dimension on the shared divider for the largest dimension count.
  localparam int QUERY_CYCLES   = 140 * MAX_DIMS + 3;
  localparam int HOLD_CYCLES    = 3000;
  localparam int WATCHDOG_LIMIT = 4 * (QUERY_CYCLES + HOLD_CYCLES + 16);
  localparam int DIRECTED_ROWS  = 25;
  localparam int RANDOM_ITEMS   = 435;

  typedef struct packed {
    logic        action;
    logic [2:0]  dim;
    logic [15:0] side;
    logic [15:0] count;
    logic [30:0] number;
  } blk_req_t;

  typedef struct packed {
    logic [2:0]  dim;
    logic [15:0] lo;
    logic [15:0] hi;
    logic        last;
    logic        oor;
  } corner_t;

  typedef struct packed {
    logic       has_cfg;
    logic [3:0] cfg;
    blk_req_t   req;
    logic       typed;
    corner_t    want;
  } dir_row_t;

  localparam corner_t NO_CORNER        = '0;
  localparam corner_t OOR_CORNER       = '{3'd0, 16'd0, 16'd0, 1'b1, 1'b1};
  localparam corner_t RESET_CORNER     = '{3'd0, 16'd0, 16'd1, 1'b1, 1'b0};
  localparam corner_t ZERO_SIDE_CORNER = '{3'd0, 16'd0, 16'd0, 1'b1, 1'b0};

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata  = '0;
  logic        s_tuser  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  // Own copy of the dimension tables and the dimension count.
  logic [15:0] side_tab  [MAX_DIMS];
  logic [15:0] count_tab [MAX_DIMS];
  logic [3:0]  cfg_dims = 4'd1;

  // Corner pairs still to arrive, oldest first.
  corner_t corner_q [$];

  bit          send_eager   = 1'b0;
  bit          recv_eager   = 1'b0;
  int unsigned hold_request = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_fail = 0, n_sets = 0, n_queries = 0, n_results = 0, n_oor = 0, n_cfg = 0;

  block_corner_address_generator_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    for (int k = 0; k < MAX_DIMS; k++) begin
      side_tab[k]  = 16'd1;
      count_tab[k] = 16'd1;
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    n_fail++;
  endtask

  function automatic int unsigned dims_active();
    if (cfg_dims == 4'd0) return 1;
    if (cfg_dims > MAX_DIMS) return MAX_DIMS;
    return 32'(cfg_dims);
  endfunction

  // Product of the block counts in use, saturated above any block number.
  function automatic longint unsigned block_total();
    longint unsigned total;
    int unsigned k;
    total = 1;
    for (k = 0; k < dims_active(); k++) begin
      total = total * 64'(count_tab[k]);
      if (total > TOTAL_CAP) total = TOTAL_CAP;
    end
    return total;
  endfunction

  // A set transaction updates the tables; a query splits its block number
  // in mixed radix and queues one corner pair per dimension in use, or one out-of-range result.
  function automatic void compute_corners(blk_req_t req);
    longint unsigned rem, p, n, t;
    int unsigned d, k;
    corner_t c;
    if (req.action == ACT_SET) begin
      if (req.dim < MAX_DIMS) begin
        side_tab[req.dim]  = req.side & SIDE_MASK;
        count_tab[req.dim] = req.count;
      end
      return;
    end
    rem = 64'(req.number);
    d = dims_active();
    if (rem >= block_total()) begin
      corner_q.push_back(OOR_CORNER);
      return;
    end
    for (k = 0; k < d; k++) begin
      p = 64'(count_tab[k]);
      n = 64'(side_tab[k]);
      t = rem % p;
      rem = rem / p;
      c.dim  = 3'(k);
      c.lo   = 16'((t * n + p - 1) / p);
      c.hi   = 16'(((t + 1) * n + p - 1) / p);
      c.last = (k + 1 == d);
      c.oor  = 1'b0;
      corner_q.push_back(c);
    end
  endfunction

  function automatic blk_req_t set_req(logic [2:0] dim, logic [15:0] side, logic [15:0] count);
    blk_req_t r;
    r = '{ACT_SET, dim, side, count, 31'($urandom)};
    return r;
  endfunction

  function automatic blk_req_t query_req(logic [30:0] number);
    blk_req_t r;
    r = '{ACT_QUERY, 3'($urandom), 16'($urandom), 16'($urandom), number};
    return r;
  endfunction

  function automatic logic [15:0] pick_side();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'd0;
    if (r < 4) return 16'($urandom_range(1, 20));
    return 16'($urandom_range(0, 65535));
  endfunction

  // Mostly small counts so that in-range numbers reach every digit.
  function automatic logic [15:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 59);
    if (r == 0) return 16'd0;
    if (r < 40) return 16'($urandom_range(1, 8));
    if (r < 52) return 16'($urandom_range(1, 300));
    return 16'($urandom_range(1, 65535));
  endfunction

  function automatic logic [30:0] pick_number(int kind);
    longint unsigned total, lim;
    int unsigned r;
    total = block_total();
    r = $urandom_range(0, 3);
    if (total == 0) return 31'($urandom);
    if (kind == NUM_OUT && total <= 64'h7FFF_FFFF) begin
      if (r == 0) return 31'(total);
      return 31'($urandom_range(32'(total), 32'h7FFF_FFFF));
    end
    lim = total - 1;
    if (lim > 64'h7FFF_FFFF) lim = 64'h7FFF_FFFF;
    if (r == 0) return 31'd0;
    if (r == 1) return 31'(lim);
    return 31'($urandom_range(0, 32'(lim)));
  endfunction

  // Offer one transaction after a random gap and model it once accepted.
  task automatic send_item(blk_req_t req, logic typed, corner_t want);
    int unsigned gap;
    gap = send_eager ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, req.number, req.count, req.side, req.dim};
    s_tuser  <= req.action;
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    if (typed && req.action == ACT_QUERY) corner_q.push_back(want);
    else compute_corners(req);
    if (req.action == ACT_SET) n_sets++;
    else n_queries++;
  endtask

  // Wait until every corner pair has come, then let any work still under
  // way in the block run out before touching the register.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (corner_q.size() != 0) @(posedge clk);
    repeat (QUERY_CYCLES) @(posedge clk);
  endtask

  // Write num_dims, then read it back.
  task automatic write_num_dims(logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= NUM_DIMS_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    cfg_dims = value[3:0];
    n_cfg++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (prdata !== {28'd0, value[3:0]}) begin
      report_mismatch("num_dims read-back", prdata, {28'd0, value[3:0]});
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Result side: random stalls, one long hold when asked, field checks.
  initial begin : result_sink
    int unsigned stall;
    corner_t got, want;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = recv_eager ? 0 : $urandom_range(0, 16);
      if (hold_request != 0) begin
        stall = hold_request;
        hold_request = 0;
      end
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (m_tvalid !== 1'b1) @(posedge clk);
      got = '{m_tdata[2:0], m_tdata[18:3], m_tdata[34:19], m_tlast, m_tuser};
      n_results++;
      if (got.oor === 1'b1) n_oor++;
      if (corner_q.size() == 0) begin
        report_mismatch("result with nothing pending", {got.hi, got.lo}, 32'd0);
      end else begin
        want = corner_q.pop_front();
        if (got.dim !== want.dim) report_mismatch("dim_out", 32'(got.dim), 32'(want.dim));
        if (got.lo !== want.lo) report_mismatch("lower_corner", 32'(got.lo), 32'(want.lo));
        if (got.hi !== want.hi) report_mismatch("upper_corner", 32'(got.hi), 32'(want.hi));
        if (got.last !== want.last) report_mismatch("last", 32'(got.last), 32'(want.last));
        if (got.oor !== want.oor) report_mismatch("out_of_range", 32'(got.oor), 32'(want.oor));
      end
    end
  end

  // Ends the run when no transaction of any kind completes for too long.
  always @(posedge clk) begin : watchdog
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("block_corner_address_generator_core_test: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t tab [DIRECTED_ROWS];
    blk_req_t req;
    logic [31:0] wv;
    int unsigned i, k, d, nq, sel, phase, sent;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part: reset state, extremes, zero side, zero count, out of
    // range at and beyond the product, zero and oversized num_dims.
    tab[0]  = '{1'b0, 4'd0,  query_req(31'd0), 1'b1, RESET_CORNER};
    tab[1]  = '{1'b0, 4'd0,  query_req(31'd1), 1'b1, OOR_CORNER};
    tab[2]  = '{1'b0, 4'd0,  query_req(31'h7FFF_FFFF), 1'b1, OOR_CORNER};
    tab[3]  = '{1'b0, 4'd0,  set_req(3'd0, 16'hFFFF, 16'hFFFF), 1'b0, NO_CORNER};
    tab[4]  = '{1'b0, 4'd0,  query_req(31'd0), 1'b0, NO_CORNER};
    tab[5]  = '{1'b0, 4'd0,  query_req(31'd65534), 1'b0, NO_CORNER};
    tab[6]  = '{1'b0, 4'd0,  query_req(31'd65535), 1'b1, OOR_CORNER};
    tab[7]  = '{1'b0, 4'd0,  set_req(3'd0, 16'd0, 16'd5), 1'b0, NO_CORNER};
    tab[8]  = '{1'b0, 4'd0,  query_req(31'd3), 1'b1, ZERO_SIDE_CORNER};
    tab[9]  = '{1'b0, 4'd0,  set_req(3'd1, 16'd7, 16'd0), 1'b0, NO_CORNER};
    tab[10] = '{1'b1, 4'd2,  query_req(31'd0), 1'b1, OOR_CORNER};
    tab[11] = '{1'b0, 4'd0,  set_req(3'd1, 16'd7, 16'd3), 1'b0, NO_CORNER};
    tab[12] = '{1'b0, 4'd0,  query_req(31'd14), 1'b0, NO_CORNER};
    tab[13] = '{1'b0, 4'd0,  query_req(31'd15), 1'b1, OOR_CORNER};
    tab[14] = '{1'b1, 4'd0,  query_req(31'd4), 1'b1, ZERO_SIDE_CORNER};
    tab[15] = '{1'b0, 4'd0,  query_req(31'd5), 1'b1, OOR_CORNER};
    tab[16] = '{1'b0, 4'd0,  set_req(3'd0, 16'd100, 16'd5), 1'b0, NO_CORNER};
    tab[17] = '{1'b1, 4'd15, set_req(3'd7, 16'hFFFF, 16'd2), 1'b0, NO_CORNER};
    tab[18] = '{1'b0, 4'd0,  query_req(31'd29), 1'b0, NO_CORNER};
    tab[19] = '{1'b0, 4'd0,  query_req(31'd30), 1'b1, OOR_CORNER};
    tab[20] = '{1'b0, 4'd0,  set_req(3'd2, 16'hAAAA, 16'h5555), 1'b0, NO_CORNER};
    tab[21] = '{1'b0, 4'd0,  query_req(31'd655349), 1'b0, NO_CORNER};
    tab[22] = '{1'b0, 4'd0,  set_req(3'd3, 16'h5555, 16'hAAAA), 1'b0, NO_CORNER};
    tab[23] = '{1'b1, 4'd8,  query_req(31'h7FFF_FFFF), 1'b0, NO_CORNER};
    tab[24] = '{1'b0, 4'd0,  query_req(31'h2AAA_AAAA), 1'b0, NO_CORNER};

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      if (tab[i].has_cfg) begin
        wait_drained();
        write_num_dims({28'd0, tab[i].cfg});
      end
      send_item(tab[i].req, tab[i].typed, tab[i].want);
    end

    // Random phases: a new dimension count, every dimension in use set up,
    // then mostly in-range queries with some out-of-range ones and noise.
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_drained();
      wv = $urandom;
      sel = $urandom_range(0, 7);
      case (sel)
        0: wv[3:0] = 4'd1;
        1: wv[3:0] = 4'd8;
        2: wv[3:0] = 4'd0;
        3: wv[3:0] = 4'd15;
        default: wv[3:0] = 4'($urandom_range(2, 5));
      endcase
      if ($urandom_range(0, 1) == 0) wv[31:4] = '0;
      write_num_dims(wv);

      send_eager = ($urandom_range(0, 3) == 0);
      recv_eager = ($urandom_range(0, 3) == 0);
      // One phase keeps the input busy while the result side holds off.
      if (phase == 2) begin
        send_eager = 1'b1;
        hold_request = HOLD_CYCLES;
      end

      d = dims_active();
      for (k = 0; k < d; k++) begin
        send_item(set_req(3'(k), pick_side(), pick_count()), 1'b0, NO_CORNER);
        sent++;
      end
      nq = $urandom_range(6, 14);
      repeat (nq) begin
        sel = $urandom_range(0, 9);
        case (sel)
          0: req = set_req(3'($urandom_range(0, 7)), pick_side(), pick_count());
          1: req = query_req(pick_number(NUM_OUT));
          2: req = query_req(31'($urandom));
          default: req = query_req(pick_number(NUM_IN));
        endcase
        send_item(req, 1'b0, NO_CORNER);
        sent++;
      end
      phase++;
    end

    wait_drained();
    $display("covered %0d set and %0d query transactions giving %0d results, %0d out of range",
             n_sets, n_queries, n_results, n_oor);
    $display("%0d num_dims writes over %0d phases, one result-side hold of %0d cycles",
             n_cfg, phase, HOLD_CYCLES);
    if (n_fail == 0) begin
      $display("block_corner_address_generator_core_test: PASS");
    end else begin
      $display("block_corner_address_generator_core_test: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/bcag_pkg.sv
hw/rtl/block_corner_address_generator_core.sv
dv/block_corner_address_generator_core_test.sv
